/* rtl/core/ggws_pkg.sv */
// Shared types and constants for the glyph grid width scan block.
// No dependencies; imported by ggws_cell and glyph_grid_width_scan_unit.
package ggws_pkg;

    // Grid geometry: the atlas is 16 cells by 16 cells
    localparam int GRID_CELLS = 16;
    localparam int CELL_IDX_W = 4;
    localparam logic [CELL_IDX_W-1:0] LAST_CELL = CELL_IDX_W'(GRID_CELLS - 1);

    // Configuration register indexes and reset values
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_WIDTH  = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CELL_HEIGHT = 8'd1;
    localparam logic [CFG_DATA_W-1:0] CELL_SIZE_RESET = 7'd8;

    // Result field widths and blank-cell advances
    localparam int CODE_W  = 8;
    localparam int LEFT_W  = 10;
    localparam int WIDTH_W = 7;
    localparam logic [CODE_W-1:0]  SPACE_CODE    = 8'd32;
    localparam logic [WIDTH_W-1:0] SPACE_ADVANCE = 7'd4;
    localparam logic [WIDTH_W-1:0] BLANK_ADVANCE = 7'd3;

    // Controls broadcast from the top level to every cell
    typedef struct packed {
        logic hit;      // accepted pixel with nonzero alpha
        logic row_end;  // accepted pixel is the last of its cell row
        logic shift;    // head result taken, chain moves one place
        logic restart;  // register write, clear trackers
    } cell_ctrl_t;

endpackage

/* rtl/core/ggws_cell.sv */
// One cell of the width scan chain: opaque-column tracker plus a result slot.
// Depends on ggws_pkg; instantiated 16 times by glyph_grid_width_scan_unit.
module ggws_cell
    import ggws_pkg::*;
#(
    parameter int XW = 6
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  cell_ctrl_t    ctrl,
    input  logic          sel,
    input  logic [XW-1:0] x_in,
    input  logic          nb_valid,
    input  logic          nb_seen,
    input  logic [XW-1:0] nb_min,
    input  logic [XW-1:0] nb_max,
    output logic          slot_valid,
    output logic          slot_seen,
    output logic [XW-1:0] slot_min,
    output logic [XW-1:0] slot_max
);

    logic          seen_reg, seen_next;
    logic [XW-1:0] min_reg, min_next;
    logic [XW-1:0] max_reg, max_next;
    logic          sv_reg, sv_next;
    logic          ss_reg, ss_next;
    logic [XW-1:0] smin_reg, smin_next;
    logic [XW-1:0] smax_reg, smax_next;

    logic          hit;
    logic          upd_seen;
    logic [XW-1:0] upd_min;
    logic [XW-1:0] upd_max;

    // Tracker update for this pixel
    always_comb begin
        hit      = ctrl.hit && sel;
        upd_seen = seen_reg || hit;
        upd_min  = (hit && (!seen_reg || x_in < min_reg)) ? x_in : min_reg;
        upd_max  = (hit && (!seen_reg || x_in > max_reg)) ? x_in : max_reg;
    end

    // Tracker and slot next state
    always_comb begin
        seen_next = upd_seen;
        min_next  = upd_min;
        max_next  = upd_max;
        sv_next   = sv_reg;
        ss_next   = ss_reg;
        smin_next = smin_reg;
        smax_next = smax_reg;
        if (ctrl.restart) begin
            seen_next = 1'b0;
        end else if (ctrl.row_end) begin
            // snapshot includes the row's last pixel, then clear
            seen_next = 1'b0;
            sv_next   = 1'b1;
            ss_next   = upd_seen;
            smin_next = upd_min;
            smax_next = upd_max;
        end else if (ctrl.shift) begin
            sv_next   = nb_valid;
            ss_next   = nb_seen;
            smin_next = nb_min;
            smax_next = nb_max;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
            sv_reg   <= 1'b0;
        end else begin
            seen_reg <= seen_next;
            sv_reg   <= sv_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        min_reg  <= min_next;
        max_reg  <= max_next;
        ss_reg   <= ss_next;
        smin_reg <= smin_next;
        smax_reg <= smax_next;
    end

    assign slot_valid = sv_reg;
    assign slot_seen  = ss_reg;
    assign slot_min   = smin_reg;
    assign slot_max   = smax_reg;

endmodule

/* rtl/core/glyph_grid_width_scan_unit.sv */
// Glyph grid width scan, top level: position counters, 16-cell chain, result head.
// Depends on ggws_pkg and ggws_cell.
//
// Usage: alpha bytes of a 16x16 glyph atlas enter on s_ (valid/ready), one
// pixel per item in raster order. Each cell of the current cell row keeps its
// leftmost and rightmost opaque column. The last pixel of a cell row loads all
// 16 cells' trackers into their result slots; the slots then shift toward
// cell 0 and leave on m_ as 16 items in character order, the first in the
// cycle after that pixel, one per cycle while m_ready is high.
// Throughput: one pixel per cycle. The burst drains while the next cell row
// streams in; only the last pixel of a cell row waits (s_ready low) while the
// previous burst still occupies the chain. At full output rate that happens
// only with 1x1 cells (16 pixels per cell row against 16 results).
// A stalled receiver holds the head result and the chain in place.
// Reset: registers back to 8x8 cells, scan at the image origin, chain empty.
// A register write (cfg_) restarts the scan; write only while idle.
module glyph_grid_width_scan_unit
    import ggws_pkg::*;
#(
    parameter int MAX_CELL_SIZE = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // pixel input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_alpha,
    // results
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [CODE_W-1:0]     m_char_code,
    output logic [LEFT_W-1:0]     m_left_x,
    output logic [WIDTH_W-1:0]    m_glyph_width,
    output logic [WIDTH_W-1:0]    m_advance,
    output logic                  m_is_blank,
    output logic                  m_last_of_run
);

    localparam int XW = (MAX_CELL_SIZE > 1) ? $clog2(MAX_CELL_SIZE) : 1;
    localparam int EW = $clog2(MAX_CELL_SIZE + 1);

    logic [CFG_DATA_W-1:0] cell_width_reg, cell_width_next;
    logic [CFG_DATA_W-1:0] cell_height_reg, cell_height_next;
    logic [EW-1:0]         cw_eff, ch_eff;

    logic [XW-1:0]         x_reg, x_next;
    logic [CELL_IDX_W-1:0] col_reg, col_next;
    logic [XW-1:0]         y_reg, y_next;
    logic [CELL_IDX_W-1:0] row_reg, row_next;

    logic [CELL_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [CELL_IDX_W-1:0] row_code_reg, row_code_next;
    logic [LEFT_W-1:0]     origin_reg, origin_next;

    logic cfg_acc, s_acc, m_acc, restart;
    logic x_last, y_last, row_end_pos;
    cell_ctrl_t ctrl;

    logic          slot_valid [GRID_CELLS];
    logic          slot_seen  [GRID_CELLS];
    logic [XW-1:0] slot_min   [GRID_CELLS];
    logic [XW-1:0] slot_max   [GRID_CELLS];
    logic [WIDTH_W-1:0] span;

    // Handshakes
    assign cfg_ready   = 1'b1;
    assign cfg_acc     = cfg_valid && cfg_ready;
    assign row_end_pos = x_last && (col_reg == LAST_CELL) && y_last;
    assign s_ready     = !(row_end_pos && m_valid);
    assign s_acc       = s_valid && s_ready;
    assign m_acc       = m_valid && m_ready;

    // Register writes; any known index restarts the scan
    always_comb begin
        cell_width_next  = cell_width_reg;
        cell_height_next = cell_height_reg;
        restart          = 1'b0;
        if (cfg_acc) begin
            unique case (cfg_addr)
                REG_CELL_WIDTH: begin
                    cell_width_next = cfg_wdata;
                    restart         = 1'b1;
                end
                REG_CELL_HEIGHT: begin
                    cell_height_next = cfg_wdata;
                    restart          = 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Effective cell size: zero acts as one, clamp to the maximum
    always_comb begin
        if (cell_width_reg == '0) begin
            cw_eff = EW'(1);
        end else if (int'(cell_width_reg) > MAX_CELL_SIZE) begin
            cw_eff = EW'(MAX_CELL_SIZE);
        end else begin
            cw_eff = EW'(cell_width_reg);
        end
        if (cell_height_reg == '0) begin
            ch_eff = EW'(1);
        end else if (int'(cell_height_reg) > MAX_CELL_SIZE) begin
            ch_eff = EW'(MAX_CELL_SIZE);
        end else begin
            ch_eff = EW'(cell_height_reg);
        end
    end

    // Pixel position counters
    assign x_last = (EW'(x_reg) == cw_eff - EW'(1));
    assign y_last = (EW'(y_reg) == ch_eff - EW'(1));

    always_comb begin
        x_next   = x_reg;
        col_next = col_reg;
        y_next   = y_reg;
        row_next = row_reg;
        if (restart) begin
            x_next   = '0;
            col_next = '0;
            y_next   = '0;
            row_next = '0;
        end else if (s_acc) begin
            if (!x_last) begin
                x_next = x_reg + XW'(1);
            end else begin
                x_next   = '0;
                col_next = col_reg + CELL_IDX_W'(1);
                if (col_reg == LAST_CELL) begin
                    y_next = y_last ? '0 : y_reg + XW'(1);
                    if (y_last) begin
                        row_next = row_reg + CELL_IDX_W'(1);
                    end
                end
            end
        end
    end

    // Cell controls
    always_comb begin
        ctrl.restart = restart;
        ctrl.hit     = s_acc && (s_alpha != '0);
        ctrl.row_end = s_acc && row_end_pos;
        ctrl.shift   = m_acc;
    end

    // Chain of cells; slot k refills from slot k+1
    for (genvar k = 0; k < GRID_CELLS; k++) begin : g_cell
        logic          nb_valid, nb_seen;
        logic [XW-1:0] nb_min, nb_max;
        if (k == GRID_CELLS - 1) begin : g_tail
            assign nb_valid = 1'b0;
            assign nb_seen  = 1'b0;
            assign nb_min   = '0;
            assign nb_max   = '0;
        end else begin : g_link
            assign nb_valid = slot_valid[k+1];
            assign nb_seen  = slot_seen[k+1];
            assign nb_min   = slot_min[k+1];
            assign nb_max   = slot_max[k+1];
        end
        ggws_cell #(
            .XW(XW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .sel       (col_reg == CELL_IDX_W'(k)),
            .x_in      (x_reg),
            .nb_valid  (nb_valid),
            .nb_seen   (nb_seen),
            .nb_min    (nb_min),
            .nb_max    (nb_max),
            .slot_valid(slot_valid[k]),
            .slot_seen (slot_seen[k]),
            .slot_min  (slot_min[k]),
            .slot_max  (slot_max[k])
        );
    end

    // Result head: cell index, row code and cell origin of the head slot
    always_comb begin
        out_idx_next  = out_idx_reg;
        row_code_next = row_code_reg;
        origin_next   = origin_reg;
        if (ctrl.row_end) begin
            out_idx_next  = '0;
            row_code_next = row_reg;
            origin_next   = '0;
        end else if (m_acc) begin
            out_idx_next = out_idx_reg + CELL_IDX_W'(1);
            origin_next  = origin_reg + LEFT_W'(cw_eff);
        end
    end

    // Result fields from the head slot
    assign span          = WIDTH_W'(slot_max[0]) - WIDTH_W'(slot_min[0]) + WIDTH_W'(1);
    assign m_valid       = slot_valid[0];
    assign m_char_code   = {row_code_reg, out_idx_reg};
    assign m_is_blank    = !slot_seen[0];
    assign m_last_of_run = (out_idx_reg == LAST_CELL);
    assign m_left_x      = slot_seen[0] ? origin_reg + LEFT_W'(slot_min[0]) : origin_reg;
    assign m_glyph_width = slot_seen[0] ? span : '0;
    assign m_advance     = slot_seen[0] ? span + WIDTH_W'(1) :
                           (m_char_code == SPACE_CODE) ? SPACE_ADVANCE : BLANK_ADVANCE;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_width_reg  <= CELL_SIZE_RESET;
            cell_height_reg <= CELL_SIZE_RESET;
            x_reg           <= '0;
            col_reg         <= '0;
            y_reg           <= '0;
            row_reg         <= '0;
            out_idx_reg     <= '0;
        end else begin
            cell_width_reg  <= cell_width_next;
            cell_height_reg <= cell_height_next;
            x_reg           <= x_next;
            col_reg         <= col_next;
            y_reg           <= y_next;
            row_reg         <= row_next;
            out_idx_reg     <= out_idx_next;
        end
    end

    // Head payload
    always_ff @(posedge aclk) begin
        row_code_reg <= row_code_next;
        origin_reg   <= origin_next;
    end

`ifndef SYNTHESIS
    // A cell row is only closed into an empty chain
    a_load_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.row_end |-> !m_valid)
        else $error("row loaded into a busy chain");

    // Burst starts at cell 0 right after the row's last pixel
    a_burst_start: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.row_end |=> (m_valid && out_idx_reg == '0))
        else $error("burst did not start at cell 0");

    // Sixteenth result empties the chain
    a_burst_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_acc && m_last_of_run) |=> !m_valid)
        else $error("chain not empty after last result");

    // Column counter stays inside the cell
    a_x_range: assert property (@(posedge aclk) disable iff (!aresetn)
        EW'(x_reg) < cw_eff)
        else $error("x position beyond cell width");
`endif

endmodule

/* verif/glyph_grid_width_scan_unit_test.sv */
// Testbench for glyph_grid_width_scan_unit: streams atlas alpha bytes and checks each glyph result.
// It checks each result against a behavioral scan predictor kept in this file.
// Depends on ggws_pkg and the glyph_grid_width_scan_unit RTL.
module glyph_grid_width_scan_unit_test;
    import ggws_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_CELL       = 64;
    localparam int SPACE_CHAR     = 32;
    localparam int SPACE_ADV      = 4;
    localparam int BLANK_ADV      = 3;
    localparam int DRAIN_CYCLES   = 24;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [CFG_ADDR_W-1:0] UNUSED_REG = 8'd2;

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [LEFT_W-1:0]  left;
        logic [WIDTH_W-1:0] width;
        logic [WIDTH_W-1:0] adv;
        logic               blank;
        logic               last;
    } glyph_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_alpha;
    logic                  m_valid;
    logic                  m_ready;
    logic [CODE_W-1:0]     m_char_code;
    logic [LEFT_W-1:0]     m_left_x;
    logic [WIDTH_W-1:0]    m_glyph_width;
    logic [WIDTH_W-1:0]    m_advance;
    logic                  m_is_blank;
    logic                  m_last_of_run;

    glyph_grid_width_scan_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_alpha       (s_alpha),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_char_code   (m_char_code),
        .m_left_x      (m_left_x),
        .m_glyph_width (m_glyph_width),
        .m_advance     (m_advance),
        .m_is_blank    (m_is_blank),
        .m_last_of_run (m_last_of_run)
    );

    // Predictor state: registers, per-cell trackers, scan position
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    int   min_col [GRID_CELLS];
    int   max_col [GRID_CELLS];
    bit   col_seen [GRID_CELLS];
    int   x_pos, col_pos, y_pos, row_pos;

    glyph_result_t pending_glyphs[$];

    int error_count;
    int pixels_sent;
    int glyphs_checked;
    int reg_writes;
    int send_gap_pct;
    int recv_stall_pct;
    int stall_cycles;
    bit hold_req;
    bit hold_ack;

    // Clock, 10 ns period
    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_size(logic [CFG_DATA_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_CELL) return MAX_CELL;
        return int'(v);
    endfunction

    function automatic void clear_scan();
        for (int k = 0; k < GRID_CELLS; k++) begin
            min_col[k]  = 0;
            max_col[k]  = 0;
            col_seen[k] = 1'b0;
        end
        x_pos   = 0;
        col_pos = 0;
        y_pos   = 0;
        row_pos = 0;
    endfunction

    // Advance the scan by one pixel; the last pixel of a cell row queues 16 glyphs
    function automatic void scan_pixel(logic [7:0] a);
        int cw;
        int ch;
        int code;
        int origin;
        glyph_result_t r;
        cw = eff_size(width_reg);
        ch = eff_size(height_reg);
        if (a != 0) begin
            if (!col_seen[col_pos]) begin
                col_seen[col_pos] = 1'b1;
                min_col[col_pos]  = x_pos;
                max_col[col_pos]  = x_pos;
            end else begin
                if (x_pos < min_col[col_pos]) min_col[col_pos] = x_pos;
                if (x_pos > max_col[col_pos]) max_col[col_pos] = x_pos;
            end
        end
        if (x_pos + 1 < cw) begin
            x_pos++;
            return;
        end
        x_pos = 0;
        if (col_pos < GRID_CELLS - 1) begin
            col_pos++;
            return;
        end
        col_pos = 0;
        if (y_pos + 1 < ch) begin
            y_pos++;
            return;
        end
        y_pos = 0;
        for (int k = 0; k < GRID_CELLS; k++) begin
            code   = row_pos * GRID_CELLS + k;
            origin = k * cw;
            r.code = CODE_W'(code);
            if (col_seen[k]) begin
                r.left  = LEFT_W'(origin + min_col[k]);
                r.width = WIDTH_W'(max_col[k] - min_col[k] + 1);
                r.adv   = WIDTH_W'(max_col[k] - min_col[k] + 2);
                r.blank = 1'b0;
            end else begin
                r.left  = LEFT_W'(origin);
                r.width = '0;
                r.adv   = (code == SPACE_CHAR) ? WIDTH_W'(SPACE_ADV) : WIDTH_W'(BLANK_ADV);
                r.blank = 1'b1;
            end
            r.last = (k == GRID_CELLS - 1);
            pending_glyphs.push_back(r);
            min_col[k]  = 0;
            max_col[k]  = 0;
            col_seen[k] = 1'b0;
        end
        row_pos = (row_pos + 1) % GRID_CELLS;
    endfunction

    task automatic report_mismatch(input string what, input int code, input int got,
                                   input int want);
        error_count++;
        if (error_count <= 40)
            $display("%0t: mismatch on %s, char %0d: got %0d, expected %0d",
                     $time, what, code, got, want);
    endtask

    // Send one pixel; called and returning at a falling edge, s_valid left high
    task automatic send_pixel(input logic [7:0] a);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_alpha <= a;
        do @(posedge aclk); while (!s_ready);
        scan_pixel(a);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Register write, only once the block has drained
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        s_valid <= 1'b0;
        wait (pending_glyphs.size() == 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_CELL_WIDTH) begin
            width_reg = val;
            clear_scan();
        end else if (idx == REG_CELL_HEIGHT) begin
            height_reg = val;
            clear_scan();
        end
        reg_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic stream_pixels(input int count, input int zero_pct);
        for (int i = 0; i < count; i++)
            send_pixel(($urandom_range(99) < zero_pct) ? 8'd0 : 8'($urandom_range(255, 1)));
    endtask

    task automatic set_idle(input int gap_pct, input int stall_pct);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
    endtask

    // Register value 0 acts as 1: one cell row of single pixels, alpha extremes
    task automatic test_size_clamp_low();
        logic [7:0] pattern [16];
        pattern = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h00, 8'h55, 8'hAA, 8'h00,
                    8'h40, 8'h02, 8'h00, 8'h00, 8'h7F, 8'h04, 8'h20, 8'h00};
        write_reg(REG_CELL_WIDTH, 7'd0);
        write_reg(REG_CELL_HEIGHT, 7'd0);
        foreach (pattern[i]) send_pixel(pattern[i]);
    endtask

    // Writes restart the scan mid-row; a write to an unused index does not
    task automatic test_scan_restart();
        write_reg(REG_CELL_WIDTH, 7'd2);
        write_reg(REG_CELL_HEIGHT, 7'd1);
        stream_pixels(12, 50);
        write_reg(UNUSED_REG, 7'd5);
        stream_pixels(20, 50);
        stream_pixels(6, 30);
        write_reg(REG_CELL_WIDTH, 7'd1);
        stream_pixels(16, 60);
    endtask

    // Receiver holds off while the sender keeps streaming, filling the chain
    task automatic test_output_backpressure();
        write_reg(REG_CELL_WIDTH, 7'd1);
        write_reg(REG_CELL_HEIGHT, 7'd1);
        hold_req = 1'b1;
        stream_pixels(32, 50);
        wait (hold_ack);
        hold_req = 1'b0;
    endtask

    // Random single-pixel-wide cells, a whole row plus a partial row
    task automatic test_random_sizes(input int segments);
        int ch;
        int row_len;
        for (int s = 0; s < segments; s++) begin
            ch = $urandom_range(2, 1);
            write_reg(REG_CELL_HEIGHT, CFG_DATA_W'(ch));
            write_reg(REG_CELL_WIDTH, 7'd1);
            row_len = GRID_CELLS * ch;
            stream_pixels(row_len + $urandom_range(7), $urandom_range(90, 20));
        end
    endtask

    // Result receiver: random stalls, or one long hold when asked
    initial begin
        int hold_left;
        hold_left = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_ack && hold_left == 0) hold_left = HOLD_CYCLES;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
                if (hold_left == 0) hold_ack = 1'b1;
            end else begin
                if (!hold_req) hold_ack = 1'b0;
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Compare each accepted result with the oldest expected glyph
    always @(posedge aclk) begin
        glyph_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_glyphs.size() == 0) begin
                report_mismatch("result with nothing expected", m_char_code, m_left_x, -1);
            end else begin
                want = pending_glyphs.pop_front();
                glyphs_checked++;
                if (m_char_code !== want.code)
                    report_mismatch("char_code", want.code, m_char_code, want.code);
                if (m_left_x !== want.left)
                    report_mismatch("left_x", want.code, m_left_x, want.left);
                if (m_glyph_width !== want.width)
                    report_mismatch("glyph_width", want.code, m_glyph_width, want.width);
                if (m_advance !== want.adv)
                    report_mismatch("advance", want.code, m_advance, want.adv);
                if (m_is_blank !== want.blank)
                    report_mismatch("is_blank", want.code, m_is_blank, want.blank);
                if (m_last_of_run !== want.last)
                    report_mismatch("last_of_run", want.code, m_last_of_run, want.last);
            end
        end
    end

    // Watchdog: too long with no item moving on any channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", stall_cycles);
            $display("[glyph_grid_width_scan_unit] ERROR");
            $finish;
        end
    end

    // Test sequence
    initial begin
        aresetn        = 1'b0;
        cfg_valid      = 1'b0;
        cfg_addr       = '0;
        cfg_wdata      = '0;
        s_valid        = 1'b0;
        s_alpha        = '0;
        hold_req       = 1'b0;
        hold_ack       = 1'b0;
        error_count    = 0;
        pixels_sent    = 0;
        glyphs_checked = 0;
        reg_writes     = 0;
        stall_cycles   = 0;
        width_reg      = 7'd8;
        height_reg     = 7'd8;
        clear_scan();
        set_idle(9, 83);
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_size_clamp_low();
        test_scan_restart();

        set_idle(83, 9);
        test_random_sizes(1);

        set_idle(0, 0);
        test_output_backpressure();

        s_valid <= 1'b0;
        wait (pending_glyphs.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("covered %0d pixels and %0d register writes, %0d glyph results checked",
                 pixels_sent, reg_writes, glyphs_checked);
        $display("small cells with zero-size clamping, mid-row restarts, unused index, stalls");
        if (error_count == 0)
            $display("[glyph_grid_width_scan_unit] OK");
        else
            $display("[glyph_grid_width_scan_unit] ERROR");
        $finish;
    end

endmodule
